>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge once reset has been released.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tokenizer assertion failed");

// Check that a condition never holds once reset has been released.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tokenizer forbidden condition seen");

`endif

>>> hw/rtl/sbt_pkg.sv
package sbt_pkg;

	// Widths of the counters and of the keyword prefix
	localparam int OFFSET_BITS     = 24;
	localparam int KEYWORD_MAX_LEN = 5;
	localparam int KW_BITS         = KEYWORD_MAX_LEN * 8;
	localparam int WIDE_BITS       = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;

	localparam logic [OFFSET_BITS-1:0] OFFSET_LIMIT = '1;
	localparam logic [23:0]            LIMIT24      = '1;
	localparam logic [15:0]            LIMIT16      = '1;

	// Token queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int COUNT_BITS = $clog2(FIFO_DEPTH + 1);

	// Token kind codes
	localparam logic [4:0] TK_IDENT    = 5'd0;
	localparam logic [4:0] TK_NUMBER   = 5'd1;
	localparam logic [4:0] TK_STRING   = 5'd2;
	localparam logic [4:0] TK_LPAREN   = 5'd3;
	localparam logic [4:0] TK_RPAREN   = 5'd4;
	localparam logic [4:0] TK_PLUS     = 5'd5;
	localparam logic [4:0] TK_MINUS    = 5'd6;
	localparam logic [4:0] TK_STAR     = 5'd7;
	localparam logic [4:0] TK_SLASH    = 5'd8;
	localparam logic [4:0] TK_ASSIGN   = 5'd9;
	localparam logic [4:0] TK_EQUALS   = 5'd10;
	localparam logic [4:0] TK_SCOPE    = 5'd11;
	localparam logic [4:0] TK_SEMI     = 5'd12;
	localparam logic [4:0] TK_NOTEQ    = 5'd13;
	localparam logic [4:0] TK_KW_INT   = 5'd14;
	localparam logic [4:0] TK_KW_WHILE = 5'd15;
	localparam logic [4:0] TK_EOF      = 5'd16;
	localparam logic [4:0] TK_UNKNOWN  = 5'd17;
	localparam logic [4:0] TK_KW_PROC  = 5'd18;
	localparam logic [4:0] TK_KW_DO    = 5'd19;
	localparam logic [4:0] TK_KW_END   = 5'd20;
	localparam logic [4:0] TK_KW_RET   = 5'd21;
	localparam logic [4:0] TK_KW_DIM   = 5'd22;
	localparam logic [4:0] TK_KW_IF    = 5'd23;
	localparam logic [4:0] TK_KW_ELSE  = 5'd24;

	// Scanner modes
	typedef enum logic [3:0] {
		M_IDLE,
		M_IDENT,
		M_NUMBER,
		M_STRING,
		M_COMMENT,
		M_SLASH,
		M_ASSIGN,
		M_COLON,
		M_BANG
	} mode_t;

	// One result transaction
	typedef struct packed {
		logic [4:0]  kind;
		logic [23:0] start;
		logic [23:0] length;
		logic [23:0] line;
		logic [15:0] column;
		logic [7:0]  odd;
		logic        unterm;
		logic        last;
	} tok_t;

	// Queue writes produced by one scanned item
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	// Clamp a counter value to the 24-bit result range
	function automatic logic [23:0] sat24(input logic [WIDE_BITS-1:0] v);
		if (v > WIDE_BITS'(LIMIT24)) begin
			return LIMIT24;
		end
		return v[23:0];
	endfunction

endpackage

>>> hw/rtl/source_byte_tokenizer.sv
// Flow: an accepted byte is held in the input register and scanned once the token queue has room;
// the tokens it closes are written into the queue, which offers them in order at the output.
// Throughput: one byte per cycle; the scan runs between the input register and a four-entry
// token queue, and input stalls while that queue holds more than two tokens.
// Reset: asynchronous, active low; clears the scanner to idle, offset 0, line 1, column 1.
module source_byte_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  source_byte,
	input  logic        end_of_source,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_kind,
	output logic [23:0] token_start,
	output logic [23:0] token_length,
	output logic [23:0] token_line,
	output logic [15:0] token_column,
	output logic [7:0]  odd_byte,
	output logic        unterminated,
	output logic        last_of_run
);
	import sbt_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       room;
	logic       advance;
	logic       accept;
	push_t      push;
	tok_t       tok_first, tok_second, out_tok;

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	// Input register: take a transaction whenever the register is empty or the held one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= source_byte;
			end_s1  <= end_of_source;
		end
	end

	sbt_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.src_byte   (byte_s1),
		.at_end     (end_s1),
		.push       (push),
		.tok_first  (tok_first),
		.tok_second (tok_second)
	);

	sbt_token_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.tok_first  (tok_first),
		.tok_second (tok_second),
		.room       (room),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_tok    (out_tok)
	);

	assign token_kind   = out_tok.kind;
	assign token_start  = out_tok.start;
	assign token_length = out_tok.length;
	assign token_line   = out_tok.line;
	assign token_column = out_tok.column;
	assign odd_byte     = out_tok.odd;
	assign unterminated = out_tok.unterm;
	assign last_of_run  = out_tok.last;

endmodule

>>> hw/rtl/sbt_scan.sv
`include "assert_macros.svh"

module sbt_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         src_byte,
	input  logic               at_end,
	output sbt_pkg::push_t     push,
	output sbt_pkg::tok_t      tok_first,
	output sbt_pkg::tok_t      tok_second
);
	import sbt_pkg::*;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_D0     = 8'h30;
	localparam logic [7:0] CH_D9     = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;

	// Keyword table, text packed first byte highest
	localparam int KW_COUNT = 9;
	localparam logic [KW_BITS-1:0] KW_WORD [KW_COUNT] = '{
		KW_BITS'(64'h70726F63), KW_BITS'(64'h646F), KW_BITS'(64'h656E64),
		KW_BITS'(64'h726574), KW_BITS'(64'h64696D), KW_BITS'(64'h6966),
		KW_BITS'(64'h656C7365), KW_BITS'(64'h496E74), KW_BITS'(64'h7768696C65)
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd4, 4'd2, 4'd3, 4'd3, 4'd3, 4'd2, 4'd4, 4'd3, 4'd5
	};
	localparam logic [4:0] KW_KIND [KW_COUNT] = '{
		TK_KW_PROC, TK_KW_DO, TK_KW_END, TK_KW_RET, TK_KW_DIM,
		TK_KW_IF, TK_KW_ELSE, TK_KW_INT, TK_KW_WHILE
	};

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || (b >= CH_HT && b <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CH_D0 && b <= CH_D9;
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ);
	endfunction

	function automatic logic ident_first(input logic [7:0] b);
		return is_alpha(b) || (b == CH_UNDER);
	endfunction

	function automatic logic ident_later(input logic [7:0] b);
		return is_alpha(b) || is_digit(b) || (b == CH_UNDER) || (b == CH_DOLLAR);
	endfunction

	mode_t                  mode_q, mode_n;
	logic [OFFSET_BITS-1:0] offset_q, begin_q, begin_n;
	logic [23:0]            line_q, bline_q, bline_n;
	logic [15:0]            col_q, bcol_q, bcol_n;
	logic [KW_BITS-1:0]     prefix_q, prefix_n;
	logic                   wide_q, wide_n;
	logic                   done_q, done_n;

	logic [OFFSET_BITS-1:0] offset_inc;
	logic [OFFSET_BITS-1:0] tok_len_raw;
	logic [4:0]             word_kind;
	logic                   consume;

	logic       pa, pa_long, pa_two, pa_unterm;
	logic [4:0] pa_kind;
	logic [7:0] pa_odd;
	logic       pb, pb_eof;
	logic [4:0] pb_kind;
	logic [7:0] pb_odd;
	logic       run_idle;

	tok_t tok_a, tok_b;

	assign offset_inc  = (offset_q == OFFSET_LIMIT) ? offset_q : offset_q + OFFSET_BITS'(1);
	assign tok_len_raw = offset_q - begin_q;

	// Match the held word against the keyword table, first entry wins
	always_comb begin
		word_kind = TK_IDENT;
		if (tok_len_raw <= OFFSET_BITS'(KEYWORD_MAX_LEN) && !wide_q) begin
			for (int i = KW_COUNT - 1; i >= 0; i--) begin
				if (OFFSET_BITS'(KW_LEN[i]) == tok_len_raw && KW_WORD[i] == prefix_q) begin
					word_kind = KW_KIND[i];
				end
			end
		end
	end

	// Next mode and the tokens this transaction closes
	always_comb begin
		mode_n    = mode_q;
		done_n    = done_q;
		begin_n   = begin_q;
		bline_n   = bline_q;
		bcol_n    = bcol_q;
		prefix_n  = prefix_q;
		wide_n    = wide_q;
		consume   = 1'b0;
		pa        = 1'b0;
		pa_long   = 1'b0;
		pa_two    = 1'b0;
		pa_unterm = 1'b0;
		pa_kind   = TK_IDENT;
		pa_odd    = CH_NUL;
		pb        = 1'b0;
		pb_eof    = 1'b0;
		pb_kind   = TK_EOF;
		pb_odd    = CH_NUL;
		run_idle  = 1'b0;

		if (step && at_end) begin
			// close whatever is pending, then report the end
			if (!done_q) begin
				unique case (mode_q)
					M_IDENT: begin
						pa = 1'b1; pa_long = 1'b1; pa_kind = word_kind;
					end
					M_NUMBER: begin
						pa = 1'b1; pa_long = 1'b1; pa_kind = TK_NUMBER;
					end
					M_STRING: begin
						pa = 1'b1; pa_long = 1'b1; pa_kind = TK_STRING; pa_unterm = 1'b1;
					end
					M_SLASH: begin
						pa = 1'b1; pa_kind = TK_SLASH;
					end
					M_ASSIGN: begin
						pa = 1'b1; pa_kind = TK_ASSIGN;
					end
					M_COLON: begin
						pa = 1'b1; pa_kind = TK_UNKNOWN; pa_odd = CH_COLON;
					end
					M_BANG: begin
						pa = 1'b1; pa_kind = TK_UNKNOWN; pa_odd = CH_BANG;
					end
					default: begin
					end
				endcase
			end
			mode_n = M_IDLE;
			pb     = 1'b1;
			pb_eof = 1'b1;
			done_n = 1'b1;
		end else if (step && !done_q) begin
			// continue the pending token or hand the byte to the idle scan
			unique case (mode_q)
				M_IDENT: begin
					if (ident_later(src_byte)) begin
						if (tok_len_raw < OFFSET_BITS'(KEYWORD_MAX_LEN)) begin
							wide_n   = wide_q || (prefix_q[KW_BITS-1 -: 8] != CH_NUL);
							prefix_n = {prefix_q[KW_BITS-9:0], src_byte};
						end
						consume = 1'b1;
					end else begin
						pa = 1'b1; pa_long = 1'b1; pa_kind = word_kind;
						mode_n = M_IDLE; run_idle = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit(src_byte)) begin
						consume = 1'b1;
					end else begin
						pa = 1'b1; pa_long = 1'b1; pa_kind = TK_NUMBER;
						mode_n = M_IDLE; run_idle = 1'b1;
					end
				end
				M_STRING: begin
					if (src_byte == CH_QUOTE) begin
						pa = 1'b1; pa_long = 1'b1; pa_kind = TK_STRING;
						mode_n = M_IDLE;
					end
					consume = 1'b1;
				end
				M_COMMENT: begin
					if (src_byte != CH_NL) begin
						consume = 1'b1;
					end else begin
						mode_n = M_IDLE; run_idle = 1'b1;
					end
				end
				M_SLASH: begin
					if (src_byte == CH_SLASH) begin
						mode_n = M_COMMENT; consume = 1'b1;
					end else begin
						pa = 1'b1; pa_kind = TK_SLASH;
						mode_n = M_IDLE; run_idle = 1'b1;
					end
				end
				M_ASSIGN: begin
					if (src_byte == CH_EQ) begin
						pa = 1'b1; pa_two = 1'b1; pa_kind = TK_EQUALS;
						mode_n = M_IDLE; consume = 1'b1;
					end else begin
						pa = 1'b1; pa_kind = TK_ASSIGN;
						mode_n = M_IDLE; run_idle = 1'b1;
					end
				end
				M_COLON: begin
					if (src_byte == CH_COLON) begin
						pa = 1'b1; pa_two = 1'b1; pa_kind = TK_SCOPE;
						mode_n = M_IDLE; consume = 1'b1;
					end else begin
						pa = 1'b1; pa_kind = TK_UNKNOWN; pa_odd = CH_COLON;
						mode_n = M_IDLE; run_idle = 1'b1;
					end
				end
				M_BANG: begin
					if (src_byte == CH_EQ) begin
						pa = 1'b1; pa_two = 1'b1; pa_kind = TK_NOTEQ;
						mode_n = M_IDLE; consume = 1'b1;
					end else begin
						pa = 1'b1; pa_kind = TK_UNKNOWN; pa_odd = CH_BANG;
						mode_n = M_IDLE; run_idle = 1'b1;
					end
				end
				default: begin
					run_idle = 1'b1;
				end
			endcase

			// scan a byte between tokens
			if (run_idle) begin
				if (is_space(src_byte)) begin
					consume = 1'b1;
				end else if (src_byte == CH_NUL) begin
					pb = 1'b1; pb_eof = 1'b1; done_n = 1'b1;
				end else begin
					begin_n = offset_q;
					bline_n = line_q;
					bcol_n  = col_q;
					consume = 1'b1;
					if (ident_first(src_byte)) begin
						prefix_n = KW_BITS'(src_byte);
						wide_n   = 1'b0;
						mode_n   = M_IDENT;
					end else if (is_digit(src_byte)) begin
						mode_n = M_NUMBER;
					end else begin
						unique case (src_byte)
							CH_QUOTE: begin
								begin_n = offset_inc; mode_n = M_STRING;
							end
							CH_SLASH:  mode_n = M_SLASH;
							CH_EQ:     mode_n = M_ASSIGN;
							CH_COLON:  mode_n = M_COLON;
							CH_BANG:   mode_n = M_BANG;
							CH_LPAREN: begin pb = 1'b1; pb_kind = TK_LPAREN; end
							CH_RPAREN: begin pb = 1'b1; pb_kind = TK_RPAREN; end
							CH_PLUS:   begin pb = 1'b1; pb_kind = TK_PLUS; end
							CH_MINUS:  begin pb = 1'b1; pb_kind = TK_MINUS; end
							CH_STAR:   begin pb = 1'b1; pb_kind = TK_STAR; end
							CH_SEMI:   begin pb = 1'b1; pb_kind = TK_SEMI; end
							default: begin
								pb = 1'b1; pb_kind = TK_UNKNOWN; pb_odd = src_byte;
							end
						endcase
					end
				end
			end
		end
	end

	// Build the pending token and the token at the current position
	always_comb begin
		tok_a.kind   = pa_kind;
		tok_a.start  = sat24(WIDE_BITS'(begin_q));
		tok_a.length = pa_long ? sat24(WIDE_BITS'(tok_len_raw)) : (pa_two ? 24'd2 : 24'd1);
		tok_a.line   = bline_q;
		tok_a.column = bcol_q;
		tok_a.odd    = pa_odd;
		tok_a.unterm = pa_unterm;
		tok_a.last   = !pb;

		tok_b.kind   = pb_kind;
		tok_b.start  = sat24(WIDE_BITS'(offset_q));
		tok_b.length = pb_eof ? 24'd0 : 24'd1;
		tok_b.line   = line_q;
		tok_b.column = col_q;
		tok_b.odd    = pb_odd;
		tok_b.unterm = 1'b0;
		tok_b.last   = 1'b1;
	end

	// Pack the tokens in order: the pending one goes first
	assign push.first  = pa || pb;
	assign push.second = pa && pb;
	assign tok_first   = pa ? tok_a : tok_b;
	assign tok_second  = tok_b;

	// Hold scanner state and advance the position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			done_q   <= 1'b0;
			offset_q <= '0;
			line_q   <= 24'd1;
			col_q    <= 16'd1;
			begin_q  <= '0;
			bline_q  <= 24'd1;
			bcol_q   <= 16'd1;
			prefix_q <= '0;
			wide_q   <= 1'b0;
		end else begin
			mode_q   <= mode_n;
			done_q   <= done_n;
			begin_q  <= begin_n;
			bline_q  <= bline_n;
			bcol_q   <= bcol_n;
			prefix_q <= prefix_n;
			wide_q   <= wide_n;
			if (consume) begin
				offset_q <= offset_inc;
				if (src_byte == CH_NL) begin
					if (line_q != LIMIT24) begin
						line_q <= line_q + 24'd1;
					end
					col_q <= 16'd1;
				end else if (col_q != LIMIT16) begin
					col_q <= col_q + 16'd1;
				end
			end
		end
	end

	`ASSERT_CLK(a_done_idle, clk, arst_n, done_q |-> mode_q == M_IDLE)
	`ASSERT_CLK(a_done_sticks, clk, arst_n, $past(done_q) |-> done_q)
	`ASSERT_NEVER(a_second_alone, clk, arst_n, push.second && !push.first)
	`ASSERT_NEVER(a_pos_zero, clk, arst_n, line_q == 24'd0 || col_q == 16'd0)

endmodule

>>> hw/rtl/sbt_token_fifo.sv
`include "assert_macros.svh"

module sbt_token_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  sbt_pkg::push_t push,
	input  sbt_pkg::tok_t  tok_first,
	input  sbt_pkg::tok_t  tok_second,
	output logic           room,
	output logic           out_valid,
	input  logic           out_stall,
	output sbt_pkg::tok_t  out_tok
);
	import sbt_pkg::*;

	tok_t                  mem_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  pop;

	assign out_valid = count_q != '0;
	assign out_tok   = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign room      = count_q <= COUNT_BITS'(FIFO_DEPTH - 2);

	// Store up to two tokens per cycle in order
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_ptr_q] <= tok_first;
		end
		if (push.second) begin
			mem_q[wr_ptr_q + PTR_BITS'(1)] <= tok_second;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(push.first) + PTR_BITS'(push.second);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			count_q <= count_q + COUNT_BITS'(push.first) + COUNT_BITS'(push.second)
				- COUNT_BITS'(pop);
		end
	end

	`ASSERT_CLK(a_count_bound, clk, arst_n, count_q <= COUNT_BITS'(FIFO_DEPTH))
	`ASSERT_NEVER(a_overfill, clk, arst_n, push.first && !room)
	`ASSERT_CLK(a_pop_drains, clk, arst_n,
		(pop && !push.first) |=> count_q == $past(count_q) - COUNT_BITS'(1))

endmodule
